// ===== src/tlb_pkg.sv =====
package tlb_pkg;

   // default sizing
   localparam int TLB_MAX_TASKS = 32;
   localparam int TLB_MAX_EDGES = 256;

   // fixed field widths
   localparam int TLB_TASK_W     = 5;
   localparam int TLB_BATCH_W    = 5;
   localparam int TLB_COUNT_W    = 6;
   localparam int TLB_REQ_DATA_W = 16;
   localparam int TLB_RSP_DATA_W = 16;

   localparam logic [TLB_COUNT_W-1:0] TLB_TASK_COUNT_RESET = 6'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INC,
      ST_SCAN_INIT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DECIDE,
      ST_EMIT,
      ST_REL_RD,
      ST_REL_PEND,
      ST_REL_WR,
      ST_STATUS
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic edge_commit;
      logic edge_drop;
      logic pend_inc;
      logic scan_clear;
      logic scan_read;
      logic scan_check;
      logic emit_start;
      logic emit_step;
      logic round_done;
      logic rel_start;
      logic rel_read;
      logic rel_check;
      logic rel_skip;
      logic rel_write;
      logic next_round;
      logic status_load;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic item_edge;
      logic item_last;
      logic item_ok;
      logic scan_end;
      logic any_left;
      logic any_ready;
      logic emit_end;
      logic emit_hit;
      logic out_free;
      logic rel_end;
      logic rel_hit;
   } sts_type;

endpackage

// ===== src/tlb_ctrl.sv =====
module tlb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  tlb_pkg::sts_type sts,
   output tlb_pkg::cmd_type cmd
);
   import tlb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.item_edge && sts.item_ok) begin
               cmd.edge_commit = 1'b1;
               state_in        = ST_INC;
            end else begin
               cmd.edge_drop = sts.item_edge;
               state_in      = sts.item_last ? ST_SCAN_INIT : ST_IDLE;
            end
         end
         ST_INC: begin
            cmd.pend_inc = 1'b1;
            state_in     = sts.item_last ? ST_SCAN_INIT : ST_IDLE;
         end
         ST_SCAN_INIT: begin
            cmd.scan_clear = 1'b1;
            state_in       = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (sts.scan_end) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            cmd.scan_check = 1'b1;
            state_in       = ST_SCAN_RD;
         end
         ST_DECIDE: begin
            if (!sts.any_left || !sts.any_ready) begin
               state_in = ST_STATUS;
            end else begin
               cmd.emit_start = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.emit_end) begin
               cmd.round_done = 1'b1;
               cmd.rel_start  = 1'b1;
               state_in       = ST_REL_RD;
            end else if (!sts.emit_hit || sts.out_free) begin
               cmd.emit_step = 1'b1;
            end
         end
         ST_REL_RD: begin
            if (sts.rel_end) begin
               cmd.next_round = 1'b1;
               state_in       = ST_SCAN_INIT;
            end else begin
               cmd.rel_read = 1'b1;
               state_in     = ST_REL_PEND;
            end
         end
         ST_REL_PEND: begin
            if (sts.rel_hit) begin
               cmd.rel_check = 1'b1;
               state_in      = ST_REL_WR;
            end else begin
               cmd.rel_skip = 1'b1;
               state_in     = ST_REL_RD;
            end
         end
         ST_REL_WR: begin
            cmd.rel_write = 1'b1;
            state_in      = ST_REL_RD;
         end
         ST_STATUS: begin
            if (sts.out_free) begin
               cmd.status_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/tlb_dpath.sv =====
module tlb_dpath #(
   parameter int MAX_TASKS = tlb_pkg::TLB_MAX_TASKS,
   parameter int MAX_EDGES = tlb_pkg::TLB_MAX_EDGES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tlb_pkg::cmd_type                    cmd,
   output tlb_pkg::sts_type                    sts,
   input  logic [tlb_pkg::TLB_REQ_DATA_W-1:0]  req_tdata,
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   input  logic                                csr_valid,
   input  logic [tlb_pkg::TLB_COUNT_W-1:0]     csr_data,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [tlb_pkg::TLB_RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import tlb_pkg::*;

   localparam int TW  = $clog2(MAX_TASKS);
   localparam int CW  = $clog2(MAX_TASKS + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int NW  = $clog2(MAX_EDGES + 1);

   // configuration
   logic [TLB_COUNT_W-1:0] task_count_ff;

   // captured item
   logic [TLB_TASK_W-1:0]  src_ff;
   logic [TLB_TASK_W-1:0]  dst_ff;
   logic                   edge_ff;
   logic                   last_ff;

   // run state
   logic [NW-1:0]          total_ff;
   logic                   dropped_ff;
   logic [MAX_TASKS-1:0]   done_ff;
   logic [MAX_TASKS-1:0]   pend_vld_ff;
   logic [MAX_TASKS-1:0]   ready_ff;
   logic [TW-1:0]          last_ready_ff;
   logic                   any_left_ff;
   logic                   any_ready_ff;
   logic [CW-1:0]          task_i_ff;
   logic [NW-1:0]          rel_e_ff;
   logic [TLB_BATCH_W-1:0] batch_ff;

   // in-degree memory
   logic [NW-1:0]          pend_mem [MAX_TASKS];
   logic [NW-1:0]          pend_rdata_ff;
   logic                   pend_rvld_ff;
   logic [TW-1:0]          pend_addr_ff;

   // edge memory, target above source
   logic [2*TW-1:0]        edge_mem [MAX_EDGES];
   logic [2*TW-1:0]        edge_rd_ff;

   // output register
   logic                      rsp_valid_ff;
   logic [TLB_RSP_DATA_W-1:0] rsp_data_ff;
   logic                      rsp_user_ff;
   logic                      rsp_last_ff;

   logic [CW-1:0]  n_tasks;
   logic [TW-1:0]  edge_s;
   logic [TW-1:0]  edge_t;
   logic [TW-1:0]  pend_raddr;
   logic           pend_ren;
   logic [NW-1:0]  pend_val;
   logic           pend_we;
   logic [NW-1:0]  pend_wdata;
   logic           out_free;
   logic           load_out;
   logic [TW-1:0]  emit_idx;
   logic           emit_eob;

   assign n_tasks = (task_count_ff > TLB_COUNT_W'(MAX_TASKS)) ? CW'(MAX_TASKS)
                                                              : CW'(task_count_ff);
   assign edge_s   = edge_rd_ff[TW-1:0];
   assign edge_t   = edge_rd_ff[2*TW-1:TW];
   assign pend_val = pend_rvld_ff ? pend_rdata_ff : '0;
   assign emit_idx = task_i_ff[TW-1:0];
   assign emit_eob = (emit_idx == last_ready_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load_out = (cmd.emit_step && sts.emit_hit) || cmd.status_load;

   always_comb begin
      sts.item_edge = edge_ff;
      sts.item_last = last_ff;
      sts.item_ok   = ({1'b0, src_ff} < TLB_COUNT_W'(n_tasks)) &&
                      ({1'b0, dst_ff} < TLB_COUNT_W'(n_tasks)) &&
                      (total_ff < NW'(MAX_EDGES));
      sts.scan_end  = (task_i_ff == n_tasks);
      sts.any_left  = any_left_ff;
      sts.any_ready = any_ready_ff;
      sts.emit_end  = (task_i_ff > CW'(last_ready_ff));
      sts.emit_hit  = ready_ff[emit_idx];
      sts.out_free  = out_free;
      sts.rel_end   = (rel_e_ff == total_ff);
      sts.rel_hit   = ready_ff[edge_s];
   end

   // one read address for the in-degree memory
   always_comb begin
      pend_ren = cmd.edge_commit || cmd.scan_read || cmd.rel_check;
      if (cmd.edge_commit) begin
         pend_raddr = TW'(dst_ff);
      end else if (cmd.scan_read) begin
         pend_raddr = task_i_ff[TW-1:0];
      end else begin
         pend_raddr = edge_t;
      end
      pend_we    = cmd.pend_inc || (cmd.rel_write && (pend_val != '0));
      pend_wdata = cmd.pend_inc ? (pend_val + NW'(1)) : (pend_val - NW'(1));
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         src_ff  <= req_tdata[TLB_TASK_W-1:0];
         dst_ff  <= req_tdata[2*TLB_TASK_W-1:TLB_TASK_W];
         edge_ff <= req_tuser;
         last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ren) begin
         pend_rdata_ff <= pend_mem[pend_raddr];
         pend_rvld_ff  <= pend_vld_ff[pend_raddr];
         pend_addr_ff  <= pend_raddr;
      end
      if (pend_we) begin
         pend_mem[pend_addr_ff] <= pend_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.edge_commit) begin
         edge_mem[total_ff[EAW-1:0]] <= {TW'(dst_ff), TW'(src_ff)};
      end
      if (cmd.rel_read) begin
         edge_rd_ff <= edge_mem[rel_e_ff[EAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= TLB_TASK_COUNT_RESET;
         total_ff      <= '0;
         dropped_ff    <= 1'b0;
         done_ff       <= '0;
         pend_vld_ff   <= '0;
         ready_ff      <= '0;
         last_ready_ff <= '0;
         any_left_ff   <= 1'b0;
         any_ready_ff  <= 1'b0;
         task_i_ff     <= '0;
         rel_e_ff      <= '0;
         batch_ff      <= '0;
      end else begin
         if (csr_valid) begin
            task_count_ff <= csr_data;
         end
         if (cmd.edge_commit) begin
            total_ff <= total_ff + NW'(1);
         end
         if (cmd.edge_drop) begin
            dropped_ff <= 1'b1;
         end
         if (pend_we) begin
            pend_vld_ff[pend_addr_ff] <= 1'b1;
         end
         if (cmd.scan_clear) begin
            ready_ff      <= '0;
            last_ready_ff <= '0;
            any_left_ff   <= 1'b0;
            any_ready_ff  <= 1'b0;
            task_i_ff     <= '0;
         end
         if (cmd.scan_check) begin
            if (!done_ff[pend_addr_ff]) begin
               any_left_ff <= 1'b1;
               if (pend_val == '0) begin
                  ready_ff[pend_addr_ff] <= 1'b1;
                  last_ready_ff          <= pend_addr_ff;
                  any_ready_ff           <= 1'b1;
               end
            end
            task_i_ff <= task_i_ff + CW'(1);
         end
         if (cmd.emit_start) begin
            task_i_ff <= '0;
         end
         if (cmd.emit_step) begin
            task_i_ff <= task_i_ff + CW'(1);
         end
         if (cmd.round_done) begin
            done_ff <= done_ff | ready_ff;
         end
         if (cmd.rel_start) begin
            rel_e_ff <= '0;
         end
         if (cmd.rel_skip || cmd.rel_write) begin
            rel_e_ff <= rel_e_ff + NW'(1);
         end
         if (cmd.next_round) begin
            batch_ff <= batch_ff + TLB_BATCH_W'(1);
         end
         if (cmd.status_load) begin
            total_ff    <= '0;
            dropped_ff  <= 1'b0;
            done_ff     <= '0;
            pend_vld_ff <= '0;
            batch_ff    <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         if (cmd.status_load) begin
            rsp_data_ff <= {3'b000, dropped_ff, any_left_ff && !any_ready_ff, 1'b0,
                            TLB_BATCH_W'(0), TLB_TASK_W'(0)};
            rsp_user_ff <= 1'b1;
            rsp_last_ff <= 1'b1;
         end else begin
            rsp_data_ff <= {3'b000, 1'b0, 1'b0, emit_eob, batch_ff,
                            TLB_TASK_W'(task_i_ff)};
            rsp_user_ff <= 1'b0;
            rsp_last_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   ap_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> out_free)
      else $error("result register loaded while a result still waits");

   ap_run_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.status_load |=> (total_ff == '0) && (done_ff == '0) && !dropped_ff)
      else $error("run state not cleared after status");

   ap_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= NW'(MAX_EDGES))
      else $error("edge count beyond store capacity");

   ap_emit_not_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_step && sts.emit_hit) |-> !done_ff[emit_idx])
      else $error("completed task emitted again");

endmodule

// ===== src/topological_level_batcher_core.sv =====
// channel | dir | handshake               | payload
// req     | in  | req_tvalid / req_tready | tdata: source, target; tuser: edge; tlast
// rsp     | out | rsp_tvalid / rsp_tready | tdata: task, batch, flags; tuser: status; tlast
// csr     | in  | csr_valid / csr_ready   | csr_data: task_count
//
// an accepted edge is captured, checked and added to its target's in-degree, other items are
// only captured and checked; the last item also runs the batching; each round: in-degree scan
// (one memory read per task), decide, emission (may stall on the output), then release, which
// lowers each edge target's in-degree if its source was emitted; the in-degree memory and
// the edge memory each have one read port; reset is synchronous; in-degree entries carry valid
// bits, so there is no clearing pass; a waiting result sits in the output register while the block keeps working
module topological_level_batcher_core #(
   parameter int MAX_TASKS = tlb_pkg::TLB_MAX_TASKS,
   parameter int MAX_EDGES = tlb_pkg::TLB_MAX_EDGES
) (
   input  logic                               clock,
   input  logic                               reset,
   // item in
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tlb_pkg::TLB_REQ_DATA_W-1:0] req_tdata,  // source_task, target_task, zero pad
   input  logic                               req_tuser,  // edge_present
   input  logic                               req_tlast,  // last_edge
   // item out
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tlb_pkg::TLB_RSP_DATA_W-1:0] rsp_tdata,  // task_index, batch_number,
                                                          // end_of_batch, cycle_found,
                                                          // edge_error, zero pad
   output logic                               rsp_tuser,  // is_status
   output logic                               rsp_tlast,  // last
   // task count register
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tlb_pkg::TLB_COUNT_W-1:0]    csr_data
);
   import tlb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // register writes land on the next clock edge
   assign csr_ready = 1'b1;

   // sequencer for load, scan, decide, emit, release and status phases
   tlb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // edge store, in-degree memory, masks and output register
   tlb_dpath #(
      .MAX_TASKS (MAX_TASKS),
      .MAX_EDGES (MAX_EDGES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
